@@ sv/bqcm_pkg.sv @@
// ----------------------------------------------------------------------------
// bqcm_pkg
// Types and constants shared by the quad cell mapper modules.
// ----------------------------------------------------------------------------
package bqcm_pkg;

   localparam int DIV_W   = 8;            // division counts and cell positions
   localparam int COORD_W = 32;           // fixed point coordinates
   localparam int IDX_W   = 16;           // linear cell index
   localparam int W_W     = 2 * DIV_W;    // bilinear weight, also n*m
   localparam int NPT     = 4;            // cell corners per result
   localparam int NCORN   = 4;            // quad corners I, J, K, L
   localparam int NAX     = 2;            // y and z
   localparam int NLANE   = NPT * NAX;    // one blend per corner and axis
   localparam int PROD_W  = COORD_W + W_W;
   localparam int DVD_W   = COORD_W + W_W + 2;
   localparam int DSR_W   = W_W + 1;
   localparam int DSTEPS  = COORD_W;      // one quotient bit per divider stage
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;
   localparam int NREG    = NCORN * NAX;
   localparam int REG_AW  = 5;

   // quad corner order, register index is corner * NAX + axis
   localparam int CORNER_I = 0;
   localparam int CORNER_J = 1;
   localparam int CORNER_K = 2;
   localparam int CORNER_L = 3;

   typedef logic [NREG-1:0][COORD_W-1:0] corner_set_type;

   typedef struct packed {
      logic [IDX_W-1:0]                    index;
      logic                                invalid;
      logic [W_W-1:0]                      den;
      logic [NPT-1:0][NCORN-1:0][W_W-1:0]  wt;
   } cell_job_type;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic             invalid;
   } cell_meta_type;

endpackage

@@ sv/bqcm_req_if.sv @@
// ----------------------------------------------------------------------------
// bqcm_req_if
// Cell request channel: valid/ready handshake with the cell position words.
// ----------------------------------------------------------------------------
interface bqcm_req_if;
   logic                      valid;
   logic                      ready;
   logic [bqcm_pkg::DIV_W-1:0] cell_col;
   logic [bqcm_pkg::DIV_W-1:0] cell_row;
   logic [bqcm_pkg::DIV_W-1:0] div_ij;
   logic [bqcm_pkg::DIV_W-1:0] div_jk;

   modport source (output valid, cell_col, cell_row, div_ij, div_jk, input ready);
   modport sink (input valid, cell_col, cell_row, div_ij, div_jk, output ready);
endinterface

@@ sv/bqcm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bqcm_rsp_if
// Cell result channel: valid/ready handshake with cell index and corners.
// ----------------------------------------------------------------------------
interface bqcm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bqcm_pkg::IDX_W-1:0]    cell_index;
   logic signed [bqcm_pkg::COORD_W-1:0] p0_y;
   logic signed [bqcm_pkg::COORD_W-1:0] p0_z;
   logic signed [bqcm_pkg::COORD_W-1:0] p1_y;
   logic signed [bqcm_pkg::COORD_W-1:0] p1_z;
   logic signed [bqcm_pkg::COORD_W-1:0] p2_y;
   logic signed [bqcm_pkg::COORD_W-1:0] p2_z;
   logic signed [bqcm_pkg::COORD_W-1:0] p3_y;
   logic signed [bqcm_pkg::COORD_W-1:0] p3_z;
   logic                          invalid;

   modport source (output valid, cell_index, p0_y, p0_z, p1_y, p1_z, p2_y, p2_z,
                   p3_y, p3_z, invalid, input ready);
   modport sink (input valid, cell_index, p0_y, p0_z, p1_y, p1_z, p2_y, p2_z,
                 p3_y, p3_z, invalid, output ready);
endinterface

@@ sv/bqcm_csr.sv @@
// ----------------------------------------------------------------------------
// bqcm_csr
// Corner coordinate registers behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module bqcm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bqcm_pkg::REG_AW-1:0]         paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output bqcm_pkg::corner_set_type            corners
);

   bqcm_pkg::corner_set_type corner_ff;
   logic [$clog2(bqcm_pkg::NREG)-1:0] reg_sel;

   assign reg_sel = paddr[bqcm_pkg::REG_AW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= '0;
      end else if (psel && penable && pwrite) begin
         corner_ff[reg_sel] <= pwdata;
      end
   end

   assign prdata  = corner_ff[reg_sel];
   assign corners = corner_ff;

endmodule

@@ sv/bqcm_front.sv @@
// ----------------------------------------------------------------------------
// bqcm_front
// Checks each request, forms the bilinear weights and n*m, and queues the job.
// ----------------------------------------------------------------------------
module bqcm_front (
   input  logic                   clock,
   input  logic                   reset,
   bqcm_req_if.sink               req_ch,
   input  logic                   pop,
   output logic                   job_valid,
   output bqcm_pkg::cell_job_type job_head
);

   localparam int DW = bqcm_pkg::DIV_W;
   localparam int WW = bqcm_pkg::W_W;

   bqcm_pkg::cell_job_type job_in;
   bqcm_pkg::cell_job_type q_ff [bqcm_pkg::Q_DEPTH];
   logic [bqcm_pkg::Q_AW-1:0] wptr_ff, rptr_ff;
   logic [bqcm_pkg::Q_AW:0]   cnt_ff;
   logic bad, push;

   always_comb begin
      logic [DW-1:0] a, b, na, mb;
      bad = (req_ch.div_ij == '0) || (req_ch.div_jk == '0) ||
            (req_ch.cell_col >= req_ch.div_ij) || (req_ch.cell_row >= req_ch.div_jk);
      job_in.invalid = bad;
      job_in.index   = bad ? '0 : WW'(req_ch.cell_row) * WW'(req_ch.div_ij) +
                              WW'(req_ch.cell_col);
      job_in.den     = bad ? WW'(1) : WW'(req_ch.div_ij) * WW'(req_ch.div_jk);
      for (int pt = 0; pt < bqcm_pkg::NPT; pt++) begin
         a  = (pt == 1 || pt == 2) ? req_ch.cell_col + DW'(1) : req_ch.cell_col;
         b  = (pt >= 2) ? req_ch.cell_row + DW'(1) : req_ch.cell_row;
         na = req_ch.div_ij - a;
         mb = req_ch.div_jk - b;
         job_in.wt[pt][bqcm_pkg::CORNER_I] = bad ? '0 : WW'(na) * WW'(mb);
         job_in.wt[pt][bqcm_pkg::CORNER_J] = bad ? '0 : WW'(a) * WW'(mb);
         job_in.wt[pt][bqcm_pkg::CORNER_K] = bad ? '0 : WW'(a) * WW'(b);
         job_in.wt[pt][bqcm_pkg::CORNER_L] = bad ? '0 : WW'(na) * WW'(b);
      end
   end

   assign req_ch.ready = (cnt_ff != (bqcm_pkg::Q_AW+1)'(bqcm_pkg::Q_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign job_valid    = (cnt_ff != '0);
   assign job_head     = q_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= job_in;
      end
   end

endmodule

@@ sv/bqcm_back.sv @@
// ----------------------------------------------------------------------------
// bqcm_back
// Blend pipeline: weight products, rounded dividend, bit-per-stage divider
// over eight lanes (four cell corners by two axes), and the result register.
// ----------------------------------------------------------------------------
module bqcm_back (
   input  logic                     clock,
   input  logic                     reset,
   input  bqcm_pkg::corner_set_type corners,
   input  logic                     job_valid,
   input  bqcm_pkg::cell_job_type   job,
   output logic                     pop,
   bqcm_rsp_if.source               rsp_ch
);

   localparam int NL = bqcm_pkg::NLANE;
   localparam int NS = bqcm_pkg::DSTEPS;
   localparam int CW = bqcm_pkg::COORD_W;
   localparam int RW = bqcm_pkg::DSR_W;

   logic adv;

   // product stage
   logic                       m_vld_ff;
   bqcm_pkg::cell_meta_type    m_meta_ff;
   logic [bqcm_pkg::W_W-1:0]   m_den_ff;
   logic signed [bqcm_pkg::PROD_W-1:0] prod_in [NL][bqcm_pkg::NCORN];
   logic signed [bqcm_pkg::PROD_W-1:0] prod_ff [NL][bqcm_pkg::NCORN];

   // divider stages, stage 0 is loaded from the sum
   logic                    vld_ff  [NS+1];
   bqcm_pkg::cell_meta_type meta_ff [NS+1];
   logic [RW-1:0]           dsr_ff  [NS+1];
   logic [RW-1:0]           rem_ff  [NS+1][NL];
   logic [CW-1:0]           sh_ff   [NS+1][NL];
   logic [RW-1:0]           rem_in  [NS+1][NL];
   logic [CW-1:0]           sh_in   [NS+1][NL];

   logic                    rsp_valid_ff;
   bqcm_pkg::cell_meta_type rsp_meta_ff;
   logic [CW-1:0]           out_ff [NL];

   // advance every stage together whenever the result register frees up
   assign adv = !rsp_valid_ff || rsp_ch.ready;
   assign pop = adv && job_valid;

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         for (int c = 0; c < bqcm_pkg::NCORN; c++) begin
            prod_in[l][c] = $signed(corners[c * bqcm_pkg::NAX + (l % bqcm_pkg::NAX)]) *
                            $signed({1'b0, job.wt[l / bqcm_pkg::NAX][c]});
         end
      end
   end

   // dividend 2*num + den, offset by den * 2^32 so the quotient is unsigned
   always_comb begin
      logic signed [bqcm_pkg::PROD_W-1:0] sum_v;
      logic [bqcm_pkg::DVD_W-1:0]         dvd_v;
      logic [RW:0]                        t_v;
      logic                               ge_v;
      for (int l = 0; l < NL; l++) begin
         sum_v = prod_ff[l][0] + prod_ff[l][1] + prod_ff[l][2] + prod_ff[l][3];
         dvd_v = (bqcm_pkg::DVD_W'(sum_v) << 1) + bqcm_pkg::DVD_W'(m_den_ff) +
                 (bqcm_pkg::DVD_W'(m_den_ff) << CW);
         rem_in[0][l] = dvd_v[CW+RW-1:CW];
         sh_in[0][l]  = dvd_v[CW-1:0];
      end
      for (int s = 0; s < NS; s++) begin
         for (int l = 0; l < NL; l++) begin
            t_v  = {rem_ff[s][l], sh_ff[s][l][CW-1]};
            ge_v = (t_v >= {1'b0, dsr_ff[s]});
            rem_in[s+1][l] = ge_v ? RW'(t_v - {1'b0, dsr_ff[s]}) : t_v[RW-1:0];
            sh_in[s+1][l]  = {sh_ff[s][l][CW-2:0], ge_v};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s <= NS; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         m_vld_ff     <= job_valid;
         vld_ff[0]    <= m_vld_ff;
         for (int s = 0; s < NS; s++) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         rsp_valid_ff <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_meta_ff <= '{index: job.index, invalid: job.invalid};
         m_den_ff  <= job.den;
         prod_ff   <= prod_in;
         meta_ff[0] <= m_meta_ff;
         dsr_ff[0]  <= {m_den_ff, 1'b0};
         for (int s = 0; s < NS; s++) begin
            meta_ff[s+1] <= meta_ff[s];
            dsr_ff[s+1]  <= dsr_ff[s];
         end
         rem_ff <= rem_in;
         sh_ff  <= sh_in;
         rsp_meta_ff <= meta_ff[NS];
         for (int l = 0; l < NL; l++) begin
            // drop the offset by flipping the sign bit; zero bad cells
            out_ff[l] <= meta_ff[NS].invalid ? '0 :
                         (sh_ff[NS][l] ^ {1'b1, {(CW-1){1'b0}}});
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cell_index = rsp_meta_ff.index;
   assign rsp_ch.invalid    = rsp_meta_ff.invalid;
   assign rsp_ch.p0_y       = out_ff[0];
   assign rsp_ch.p0_z       = out_ff[1];
   assign rsp_ch.p1_y       = out_ff[2];
   assign rsp_ch.p1_z       = out_ff[3];
   assign rsp_ch.p2_y       = out_ff[4];
   assign rsp_ch.p2_z       = out_ff[5];
   assign rsp_ch.p3_y       = out_ff[6];
   assign rsp_ch.p3_z       = out_ff[7];

endmodule

@@ sv/bilinear_quad_cell_mapper.sv @@
// ----------------------------------------------------------------------------
// bilinear_quad_cell_mapper
// Maps a cell of a subdivided quadrilateral to its four corner coordinates.
// ----------------------------------------------------------------------------
// Takes one cell request per clock while the request queue has room, and
// returns one result word per request, in order. A request passes through
// the request queue, the weight product register, the weighted sum loaded
// into divider stage 0, the divider (one quotient bit per stage, eight lanes
// side by side) and finally the result register. A stall on the result side
// holds the whole blend pipeline; the four-deep request queue keeps taking
// words meanwhile. Corners are written through the APB-style port at byte
// address 4*i in the order I.y, I.z, J.y, J.z, K.y, K.z, L.y, L.z, and the
// user must write them only while idle; the block does not enforce this.
module bilinear_quad_cell_mapper (
   input  logic                          clock,
   input  logic                          reset,
   bqcm_req_if.sink                      req_ch,
   bqcm_rsp_if.source                    rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bqcm_pkg::REG_AW-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   bqcm_pkg::corner_set_type corners;
   bqcm_pkg::cell_job_type   job_head;
   logic                     job_valid;
   logic                     pop;

   assign pready = 1'b1;

   bqcm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .corners (corners)
   );

   bqcm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .pop       (pop),
      .job_valid (job_valid),
      .job_head  (job_head)
   );

   bqcm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .corners   (corners),
      .job_valid (job_valid),
      .job       (job_head),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

@@ verif/bqcm_scoreboard.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bqcm_scoreboard
// Watches the request, result and register ports of the quad cell mapper.
// It keeps its own copy of the corner registers and works out the four cell
// corners of each accepted request. Each result word is then compared, field
// by field and in order, against the oldest cell still expected.
// ----------------------------------------------------------------------------
module bqcm_scoreboard (
   input  logic                        clock,
   input  logic                        reset,
   bqcm_req_if                         req_mon,
   bqcm_rsp_if                         rsp_mon,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bqcm_pkg::REG_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   input  logic                        pready,
   output int                          fail_count,
   output int                          cells_pending
);

   typedef struct {
      logic [bqcm_pkg::IDX_W-1:0]          index;
      logic signed [bqcm_pkg::COORD_W-1:0] pt [bqcm_pkg::NLANE];
      logic                                invalid;
   } cell_corners_type;

   logic signed [bqcm_pkg::COORD_W-1:0] corner [bqcm_pkg::NREG];
   cell_corners_type                    expected_cells [$];

   // floor(num/den + 1/2), den > 0
   function automatic longint round_half_up(longint num, longint den);
      longint q, r;
      q = num / den;
      r = num - q * den;
      if (r < 0) begin
         q = q - 1;
         r = r + den;
      end
      if (r >= den - r) q = q + 1;
      return q;
   endfunction

   function automatic logic signed [bqcm_pkg::COORD_W-1:0] blend_axis(int axis, longint a,
                                                                      longint b, longint n,
                                                                      longint m);
      longint num;
      num = longint'(corner[bqcm_pkg::CORNER_I * bqcm_pkg::NAX + axis]) * ((n - a) * (m - b))
          + longint'(corner[bqcm_pkg::CORNER_J * bqcm_pkg::NAX + axis]) * (a * (m - b))
          + longint'(corner[bqcm_pkg::CORNER_K * bqcm_pkg::NAX + axis]) * (a * b)
          + longint'(corner[bqcm_pkg::CORNER_L * bqcm_pkg::NAX + axis]) * ((n - a) * b);
      return bqcm_pkg::COORD_W'(round_half_up(num, n * m));
   endfunction

   function automatic cell_corners_type map_cell(logic [bqcm_pkg::DIV_W-1:0] col,
                                                 logic [bqcm_pkg::DIV_W-1:0] row,
                                                 logic [bqcm_pkg::DIV_W-1:0] n,
                                                 logic [bqcm_pkg::DIV_W-1:0] m);
      cell_corners_type c;
      longint           a, b;
      c.index   = '0;
      c.invalid = 1'b1;
      foreach (c.pt[k]) c.pt[k] = '0;
      if (n != 0 && m != 0 && col < n && row < m) begin
         c.invalid = 1'b0;
         c.index   = bqcm_pkg::IDX_W'(row) * bqcm_pkg::IDX_W'(n) + bqcm_pkg::IDX_W'(col);
         for (int p = 0; p < bqcm_pkg::NPT; p++) begin
            // walk the cell corners counter-clockwise from (col,row)
            a = (p == 1 || p == 2) ? longint'(col) + 1 : longint'(col);
            b = (p >= 2) ? longint'(row) + 1 : longint'(row);
            for (int ax = 0; ax < bqcm_pkg::NAX; ax++)
               c.pt[p * bqcm_pkg::NAX + ax] = blend_axis(ax, a, b, n, m);
         end
      end
      return c;
   endfunction

   task automatic report(string field, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      cell_corners_type want;
      logic signed [bqcm_pkg::COORD_W-1:0] got_pt [bqcm_pkg::NLANE];
      if (reset) begin
         foreach (corner[i]) corner[i] = '0;
         expected_cells.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready && (paddr >> 2) < bqcm_pkg::NREG)
            corner[paddr >> 2] = pwdata;
         if (req_mon.valid && req_mon.ready)
            expected_cells.push_back(map_cell(req_mon.cell_col, req_mon.cell_row,
                                              req_mon.div_ij, req_mon.div_jk));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_cells.size() == 0) begin
               report("requests outstanding", 0, 1);
            end else begin
               want = expected_cells.pop_front();
               got_pt = '{rsp_mon.p0_y, rsp_mon.p0_z, rsp_mon.p1_y, rsp_mon.p1_z,
                          rsp_mon.p2_y, rsp_mon.p2_z, rsp_mon.p3_y, rsp_mon.p3_z};
               if (rsp_mon.cell_index !== want.index)
                  report("cell_index", rsp_mon.cell_index, want.index);
               if (rsp_mon.invalid !== want.invalid)
                  report("invalid", rsp_mon.invalid, want.invalid);
               for (int k = 0; k < bqcm_pkg::NLANE; k++)
                  if (got_pt[k] !== want.pt[k])
                     report($sformatf("p%0d_%s", k / 2, (k % 2) ? "z" : "y"),
                            got_pt[k], want.pt[k]);
            end
         end
      end
      cells_pending = expected_cells.size();
   end

endmodule

@@ verif/tb_bilinear_quad_cell_mapper.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bilinear_quad_cell_mapper
// Drives cell requests and corner settings into the quad cell mapper.
// Phases run zero, extreme and random corners; each phase sends mostly legal
// cells with random positions plus illegal ones, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_bilinear_quad_cell_mapper;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 50;
   localparam int NUM_PHASES   = 7;
   localparam int RAND_PER_PH  = 236;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [bqcm_pkg::REG_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   logic no_gaps = 1'b0;
   int fail_count, cells_pending;
   int idle_cycles = 0;

   bqcm_req_if req_ch ();
   bqcm_rsp_if rsp_ch ();

   initial begin
      req_ch.valid = 1'b0;
      req_ch.cell_col = '0;
      req_ch.cell_row = '0;
      req_ch.div_ij = '0;
      req_ch.div_jk = '0;
      rsp_ch.ready = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bilinear_quad_cell_mapper uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   bqcm_scoreboard checker_i (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .fail_count(fail_count),
      .cells_pending(cells_pending)
   );

   // watchdog: any handshake or register access resets the count
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: stall a random number of cycles before each word
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         hold = no_gaps ? 0 : $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic write_corner(int idx, logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= bqcm_pkg::REG_AW'(idx * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic send_cell(logic [7:0] col, logic [7:0] row, logic [7:0] n, logic [7:0] m);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cell_col <= col;
      req_ch.cell_row <= row;
      req_ch.div_ij   <= n;
      req_ch.div_jk   <= m;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random_cell();
      logic [7:0] n, m;
      if ($urandom_range(0, 99) < 85) begin
         n = $urandom_range(0, 3) == 0 ? 8'(255 - $urandom_range(0, 3))
                                       : 8'($urandom_range(1, 255));
         m = $urandom_range(0, 3) == 0 ? 8'(255 - $urandom_range(0, 3))
                                       : 8'($urandom_range(1, 255));
         send_cell(8'($urandom_range(0, n - 1)), 8'($urandom_range(0, m - 1)), n, m);
      end else begin
         send_cell(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (cells_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [31:0] value;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset corners: all results zero apart from index and flag
      send_cell(8'd0, 8'd0, 8'd1, 8'd1);
      send_cell(8'd3, 8'd2, 8'd0, 8'd5);
      send_cell(8'd1, 8'd1, 8'd4, 8'd0);
      send_cell(8'd0, 8'd0, 8'd0, 8'd0);
      wait_idle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         for (int r = 0; r < bqcm_pkg::NREG; r++) begin
            case (ph)
               0: value = 32'h7fff_ffff;
               1: value = 32'h8000_0000;
               2: value = (r % 3 == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
               3: value = 32'($urandom_range(0, 511)) - 32'd256;  // small, hits ties
               default: value = $urandom;
            endcase
            write_corner(r, value);
         end

         if (ph < 3) begin
            // edges of the grid and each way a request can be refused
            send_cell(8'd0, 8'd0, 8'd255, 8'd255);
            send_cell(8'd254, 8'd254, 8'd255, 8'd255);
            send_cell(8'd254, 8'd0, 8'd255, 8'd1);
            send_cell(8'd0, 8'd254, 8'd1, 8'd255);
            send_cell(8'd0, 8'd0, 8'd1, 8'd1);
            send_cell(8'd1, 8'd1, 8'd2, 8'd2);
            send_cell(8'd255, 8'd0, 8'd255, 8'd255);
            send_cell(8'd0, 8'd255, 8'd255, 8'd255);
            send_cell(8'd255, 8'd255, 8'd255, 8'd255);
            send_cell(8'd0, 8'd0, 8'd0, 8'd7);
            send_cell(8'd0, 8'd0, 8'd7, 8'd0);
            send_cell(8'd5, 8'd1, 8'd5, 8'd3);
         end

         for (int i = 0; i < RAND_PER_PH; i++) begin
            // alternate stretches with and without gaps
            if (i % 60 == 0) no_gaps <= ($urandom_range(0, 2) == 0);
            send_random_cell();
         end
         no_gaps <= 1'b0;
         wait_idle();
      end

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
